[hdl/irdl_pkg.sv]
// Shared types and constants for the IR distance linearizer.
// Holds the channel payload structs, the engine control structs and the
// calibration coefficient table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irdl_pkg;

   localparam int CHANNELS    = 4;
   localparam int CH_W        = 2;
   localparam int ADC_BITS    = 12;
   localparam int POLY_DEGREE = 6;
   localparam int SUM_W       = 20;
   localparam int COUNT_W     = 8;
   localparam int SCALE_W     = 21;
   localparam int LIMIT_W     = 8;
   localparam int DIST_W      = 24;
   localparam int COEF_W      = 26;
   localparam int CSR_W       = 21;
   localparam int CSR_IDX_W   = 3;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_SCALE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_LIMIT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_LIMIT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THRESHOLD = 3'd4;

   localparam logic [CH_W-1:0] CH_FRONT_LEFT = 2'd0;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [ADC_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]          sensor_id;
      logic signed [DIST_W-1:0] distance;
      logic                     clamped;
      logic                     start_detected;
   } rsp_type;

   // Window hand-off from the accumulators to the engine
   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  channel;
      logic [SUM_W-1:0] sum;
   } start_type;

   typedef struct packed {
      logic [SCALE_W-1:0] mean_scale;
      logic [LIMIT_W-1:0] front_limit;
      logic [LIMIT_W-1:0] side_limit;
      logic [LIMIT_W-1:0] start_threshold;
   } cfg_type;

   // Q14.12 calibration coefficients, highest degree first
   localparam logic signed [COEF_W-1:0] COEF_TABLE [0:CHANNELS-1][0:POLY_DEGREE] = '{
      '{ 26'sd2366856, -26'sd12198904, 26'sd25038519, -26'sd26707297,
         26'sd15933733, -26'sd5374373, 26'sd973958 },
      '{ -26'sd3054936, 26'sd4810757, 26'sd7739683, -26'sd23404422,
         26'sd21070917, -26'sd8693625, 26'sd1608890 },
      '{ 26'sd4458841, -26'sd18401364, 26'sd32048056, -26'sd30788542,
         26'sd17589981, -26'sd5966039, 26'sd1096384 },
      '{ 26'sd6187694, -26'sd21369297, 26'sd32522340, -26'sd29178562,
         26'sd16552581, -26'sd5738851, 26'sd1064357 }
   };

endpackage

`default_nettype wire

[hdl/irdl_engine.sv]
// Microcoded scale-and-Horner engine of the IR distance linearizer.
// Runs a seven-step program from a control ROM over one shared 22x22 multiplier.
// Depends on irdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irdl_engine (
   input  wire               clock,
   input  wire               reset,
   input  irdl_pkg::start_type start,
   input  irdl_pkg::cfg_type cfg,
   input  wire               out_free,
   output logic              busy,
   output logic              done,
   output irdl_pkg::rsp_type result
);
   import irdl_pkg::*;

   localparam int STEP_W = 3;
   localparam int K_W    = $clog2(POLY_DEGREE + 1);
   localparam int ACC_W  = 34;
   localparam int MOP_W  = 22;
   localparam int MUL_W  = 2 * MOP_W;
   localparam int PROD_W = 56;
   localparam int LO_W   = 17;

   localparam logic [1:0] MUL_NONE  = 2'd0;
   localparam logic [1:0] MUL_SCALE = 2'd1;
   localparam logic [1:0] MUL_LO    = 2'd2;
   localparam logic [1:0] MUL_HI    = 2'd3;

   localparam logic [1:0] PROD_HOLD  = 2'd0;
   localparam logic [1:0] PROD_LOAD  = 2'd1;
   localparam logic [1:0] PROD_ACCUM = 2'd2;

   localparam logic [1:0] ACC_HOLD   = 2'd0;
   localparam logic [1:0] ACC_INIT   = 2'd1;
   localparam logic [1:0] ACC_HORNER = 2'd2;

   localparam logic [STEP_W-1:0] STEP_SCALE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_XLOAD = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MLO   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MHI   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ADD   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_HORN  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;

   typedef struct packed {
      logic [1:0]        mul_sel;
      logic [1:0]        prod_op;
      logic [1:0]        acc_op;
      logic              loop;
      logic [STEP_W-1:0] target;
      logic              emit;
   } ucode_type;

   localparam ucode_type UCODE [0:6] = '{
      '{MUL_SCALE, PROD_HOLD,  ACC_HOLD,   1'b0, STEP_SCALE, 1'b0},
      '{MUL_NONE,  PROD_HOLD,  ACC_INIT,   1'b0, STEP_SCALE, 1'b0},
      '{MUL_LO,    PROD_HOLD,  ACC_HOLD,   1'b0, STEP_SCALE, 1'b0},
      '{MUL_HI,    PROD_LOAD,  ACC_HOLD,   1'b0, STEP_SCALE, 1'b0},
      '{MUL_NONE,  PROD_ACCUM, ACC_HOLD,   1'b0, STEP_SCALE, 1'b0},
      '{MUL_NONE,  PROD_HOLD,  ACC_HORNER, 1'b1, STEP_MLO,   1'b0},
      '{MUL_NONE,  PROD_HOLD,  ACC_HOLD,   1'b0, STEP_SCALE, 1'b1}
   };

   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SCALE_W-1:0]       x_ff, x_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MUL_W-1:0]  mul_ff, mul_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   ucode_type                cw;
   logic signed [MOP_W-1:0]  mul_a, mul_b;
   logic signed [MUL_W-1:0]  mul_full;
   logic signed [PROD_W-1:0] mul_ext, prod_rnd;
   logic [41:0]              x_sum;
   logic [29:0]              x_shift;
   logic [SCALE_W-1:0]       x_sat;
   logic [K_W-1:0]           k_sel;
   logic signed [COEF_W-1:0] coef;
   logic signed [ACC_W-1:0]  horner_sum;
   logic signed [ACC_W-1:0]  d_sum;
   logic signed [29:0]       d_full;
   logic signed [DIST_W-1:0] d_sat, d_lim, d_thr;
   logic [LIMIT_W-1:0]       limit;
   logic                     over;

   assign cw = UCODE[step_ff];

   // Shared multiplier: scale, then low and high halves of the accumulator
   always_comb begin
      unique case (cw.mul_sel)
         MUL_SCALE: begin
            mul_a = {2'b00, sum_ff};
            mul_b = {1'b0, cfg.mean_scale};
         end
         MUL_LO: begin
            mul_a = {{(MOP_W-LO_W){1'b0}}, acc_ff[LO_W-1:0]};
            mul_b = {1'b0, x_ff};
         end
         MUL_HI: begin
            mul_a = {{(MOP_W-LO_W){acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:LO_W]};
            mul_b = {1'b0, x_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign mul_ext  = {{(PROD_W-MUL_W){mul_ff[MUL_W-1]}}, mul_ff};

   // Normalized mean, Q1.20 rounded half up, saturated
   assign x_sum   = {1'b0, mul_ff[40:0]} + 42'd2048;
   assign x_shift = x_sum[41:12];
   assign x_sat   = (|x_shift[29:SCALE_W]) ? {SCALE_W{1'b1}} : x_shift[SCALE_W-1:0];

   assign k_sel      = (cw.acc_op == ACC_INIT) ? '0 : k_ff;
   assign coef       = COEF_TABLE[ch_ff][k_sel];
   assign prod_rnd   = prod_ff + 56'sd524288;
   assign horner_sum = $signed(prod_rnd[ACC_W+19:20])
                       + {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};

   // Output stage: round by 2^4, saturate, clamp, start compare
   assign d_sum  = acc_ff + 34'sd8;
   assign d_full = d_sum[ACC_W-1:4];
   assign over   = !((&d_full[29:DIST_W-1]) || !(|d_full[29:DIST_W-1]));
   assign limit  = ch_ff[1] ? cfg.side_limit : cfg.front_limit;

   always_comb begin
      if (over) begin
         d_sat = d_full[29] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
         d_sat = d_full[DIST_W-1:0];
      end
      d_lim = {8'd0, limit, 8'd0};
      d_thr = {8'd0, cfg.start_threshold, 8'd0};
      result.sensor_id = ch_ff;
      result.clamped   = (d_sat > d_lim);
      result.distance  = result.clamped ? d_lim : d_sat;
      result.start_detected = (ch_ff == CH_FRONT_LEFT) && (result.distance < d_thr);
   end

   assign busy = busy_ff;
   assign done = busy_ff && cw.emit && out_free;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      k_in    = k_ff;
      ch_in   = ch_ff;
      sum_in  = sum_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      mul_in  = mul_ff;
      prod_in = prod_ff;
      if (start.valid) begin
         busy_in = 1'b1;
         step_in = STEP_SCALE;
         ch_in   = start.channel;
         sum_in  = start.sum;
      end else if (busy_ff) begin
         if (cw.mul_sel != MUL_NONE) begin
            mul_in = mul_full;
         end
         unique case (cw.prod_op)
            PROD_LOAD:  prod_in = mul_ext;
            PROD_ACCUM: prod_in = prod_ff + (mul_ext <<< LO_W);
            default:    prod_in = prod_ff;
         endcase
         unique case (cw.acc_op)
            ACC_INIT: begin
               acc_in = {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};
               x_in   = x_sat;
               k_in   = K_W'(1);
            end
            ACC_HORNER: begin
               acc_in = horner_sum;
               k_in   = k_ff + K_W'(1);
            end
            default: acc_in = acc_ff;
         endcase
         // Advance, loop back for the next term, or hold at emit
         priority if (cw.emit) begin
            if (out_free) begin
               busy_in = 1'b0;
               step_in = STEP_SCALE;
            end
         end else if (cw.loop && (k_ff != K_W'(POLY_DEGREE))) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_SCALE;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         k_ff    <= k_in;
      end
      ch_ff   <= ch_in;
      sum_ff  <= sum_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      mul_ff  <= mul_in;
      prod_ff <= prod_in;
   end

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_EMIT))
      else $error("engine step counter left the program");

   // The last Horner step leaves the index one past the degree until the next window
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_W'(POLY_DEGREE + 1))
      else $error("Horner term index beyond polynomial degree");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff)
      else $error("engine still busy after delivering its result");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> !busy_ff)
      else $error("window started while engine busy");
`endif

endmodule

`default_nettype wire

[hdl/ir_distance_linearizer.sv]
// Top level of the IR distance linearizer: configuration registers, per-channel
// averaging windows, result register. Depends on irdl_pkg and irdl_engine.
//
//  port group  | dir | handshake            | payload
//  req_        | in  | req_valid/req_stall  | req_data  (channel, sample)
//  rsp_        | out | rsp_valid/rsp_stall  | rsp_data  (sensor_id, distance, clamped,
//              |     |                      |            start_detected)
//  csr_        | in  | csr_we (no wait)     | csr_index, csr_wdata
//
// A sample that does not close its window is taken while the engine is free. One that
// closes it starts the engine program: scale, load x, six Horner terms on the shared
// multiplier (low and high multiply, add, Horner step), emit; samples stall meanwhile.
// The emit step holds while a previous result still waits in the output register.
// Reset (synchronous) clears the window sums and counts and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ir_distance_linearizer (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  irdl_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output irdl_pkg::rsp_type               rsp_data,
   input  wire                             csr_we,
   input  wire [irdl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [irdl_pkg::CSR_W-1:0]       csr_wdata
);
   import irdl_pkg::*;

   // Configuration registers
   logic [COUNT_W-1:0] sample_count_ff;
   logic [SCALE_W-1:0] mean_scale_ff;
   logic [LIMIT_W-1:0] front_limit_ff;
   logic [LIMIT_W-1:0] side_limit_ff;
   logic [LIMIT_W-1:0] start_threshold_ff;

   // Per-channel window state
   logic [SUM_W-1:0]   sums_ff   [CHANNELS];
   logic [COUNT_W-1:0] counts_ff [CHANNELS];

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic               req_fire;
   logic [SUM_W-1:0]   sum_new;
   logic [COUNT_W-1:0] cnt_new;
   logic               complete;
   start_type          eng_start;
   cfg_type            eng_cfg;
   logic               eng_busy, eng_done, out_free;
   rsp_type            eng_result;

   // Take a sample only while the engine is free
   assign req_stall = eng_busy;
   assign req_fire  = req_valid && !req_stall;

   assign sum_new  = sums_ff[req_data.channel] + SUM_W'(req_data.sample);
   assign cnt_new  = counts_ff[req_data.channel] + COUNT_W'(1);
   // A zero count or a count lowered below the fill closes the window at once
   assign complete = (cnt_new >= sample_count_ff);

   assign eng_start.valid   = req_fire && complete;
   assign eng_start.channel = req_data.channel;
   assign eng_start.sum     = sum_new;

   assign eng_cfg.mean_scale      = mean_scale_ff;
   assign eng_cfg.front_limit     = front_limit_ff;
   assign eng_cfg.side_limit      = side_limit_ff;
   assign eng_cfg.start_threshold = start_threshold_ff;

   // Output register frees when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   irdl_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (eng_start),
      .cfg      (eng_cfg),
      .out_free (out_free),
      .busy     (eng_busy),
      .done     (eng_done),
      .result   (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (eng_done) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Accumulate the sample, or clear the window it closes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i]   <= '0;
            counts_ff[i] <= '0;
         end
      end else if (req_fire) begin
         if (complete) begin
            sums_ff[req_data.channel]   <= '0;
            counts_ff[req_data.channel] <= '0;
         end else begin
            sums_ff[req_data.channel]   <= sum_new;
            counts_ff[req_data.channel] <= cnt_new;
         end
      end
   end

   // Register writes: mask to register width, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff    <= 8'd100;
         mean_scale_ff      <= 21'd14317;
         front_limit_ff     <= 8'd150;
         side_limit_ff      <= 8'd160;
         start_threshold_ff <= 8'd70;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT:    sample_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_MEAN_SCALE:      mean_scale_ff      <= csr_wdata[SCALE_W-1:0];
            CSR_FRONT_LIMIT:     front_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            CSR_SIDE_LIMIT:      side_limit_ff      <= csr_wdata[LIMIT_W-1:0];
            CSR_START_THRESHOLD: start_threshold_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_start_front_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_detected) |-> (rsp_data.sensor_id == CH_FRONT_LEFT))
      else $error("start flagged on a channel other than front left");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clamped) |->
      (rsp_data.distance == $signed({8'd0,
         (rsp_data.sensor_id[1] ? side_limit_ff : front_limit_ff), 8'd0})))
      else $error("clamped distance differs from its channel limit");

   a_window_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && complete) |=> req_stall)
      else $error("closed window did not start the engine");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !eng_done)
      else $error("engine result would overwrite a waiting item");
`endif

endmodule

`default_nettype wire
